[hdl/edd_pkg.sv]
// ----------------------------------------------------------------------------
// edd_pkg
// Shared types, register indexes and arithmetic helpers for the
// error-diffusion dither block.
// ----------------------------------------------------------------------------
package edd_pkg;

   localparam int PIX_W       = 8;
   localparam int ERR_W       = 9;
   localparam int LINE_W_W    = 11;
   localparam int FRAME_H_W   = 12;
   localparam int CSR_DATA_W  = 12;
   localparam int CSR_IDX_W   = 2;

   typedef logic signed [ERR_W-1:0] err_type;
   typedef logic [PIX_W-1:0]        pix_type;
   typedef logic [CSR_IDX_W-1:0]    csr_index_type;

   localparam csr_index_type CSR_TWO_LEVEL    = 2'd0;
   localparam csr_index_type CSR_DIFFUSE      = 2'd1;
   localparam csr_index_type CSR_LINE_WIDTH   = 2'd2;
   localparam csr_index_type CSR_FRAME_HEIGHT = 2'd3;

   localparam logic                 TWO_LEVEL_RST    = 1'b0;
   localparam logic                 DIFFUSE_RST      = 1'b1;
   localparam logic [LINE_W_W-1:0]  LINE_WIDTH_RST   = 11'd900;
   localparam logic [FRAME_H_W-1:0] FRAME_HEIGHT_RST = 12'd660;

   // e * k / 16, truncated toward zero
   function automatic err_type weight_term(input err_type e, input logic [2:0] k);
      logic signed [12:0] prod;
      logic signed [12:0] adj;
      prod = e * $signed({1'b0, k});
      adj  = prod + ((prod < 0) ? 13'sd15 : 13'sd0);
      return err_type'(adj >>> 4);
   endfunction

   // v/16*17 or v/128*255
   function automatic pix_type quantize(input pix_type v, input logic two_level);
      pix_type q;
      if (two_level) begin
         q = {PIX_W{v[7]}};
      end else begin
         q = {v[7:4], v[7:4]};
      end
      return q;
   endfunction

endpackage

[hdl/edd_ram.sv]
// ----------------------------------------------------------------------------
// edd_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module edd_ram #(
   parameter int WIDTH = 9,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/error_diffusion_dither.sv]
// ----------------------------------------------------------------------------
// error_diffusion_dither
// Floyd-Steinberg requantizer for an 8-bit grey pixel stream in raster order.
// ----------------------------------------------------------------------------
// One pixel is taken per clock, sustained, while the output side does not
// stall; each pixel is held in the s1 registers and then in the output
// register. The line buffer of next-row corrections is read when a pixel is
// taken; in the following cycle the corrected value, its quantization and the
// four error terms are formed, and the right-carry term is registered for the
// next pixel, which keeps the one-pixel-per-clock rate. The buffer entry
// of the previous column is held in a register until its below-left term
// arrives, and is forwarded to any read of that column. The line buffer is not
// cleared; the first row of a frame ignores it. The user must write
// configuration only while no pixel is in flight; it is not enforced here.
// ----------------------------------------------------------------------------
module error_diffusion_dither #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [7:0]                       req_pixel_in,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [7:0]                       rsp_pixel_out,
   output logic                             rsp_frame_last,
   input  logic                             csr_wr_en,
   input  edd_pkg::csr_index_type           csr_index,
   input  logic [edd_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   import edd_pkg::*;

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int WW = (AW + 1 > LINE_W_W) ? AW + 1 : LINE_W_W;

   // configuration
   logic                 two_level_ff;
   logic                 diffuse_ff;
   logic [LINE_W_W-1:0]  line_width_ff;
   logic [FRAME_H_W-1:0] frame_height_ff;

   // position of the next pixel
   logic [AW-1:0]        col_ff, col_in;
   logic [FRAME_H_W-1:0] row_ff, row_in;

   // pixel waiting for its line-buffer read
   logic                 s1_valid_ff;
   pix_type              s1_pix_ff;
   logic [AW-1:0]        s1_col_ff;
   logic                 s1_row_zero_ff;
   logic                 s1_last_col_ff;
   logic                 s1_last_row_ff;

   // read-during-write capture
   logic                 byp_hit_ff;
   err_type              byp_data_ff;

   // buffer entry of the last processed column, not yet written
   logic                 pend_valid_ff;
   err_type              pend_ff, pend_in;
   logic [AW-1:0]        pend_addr_ff;

   err_type              right_carry_ff, right_carry_in;
   err_type              below_right_ff, below_right_in;

   logic                 rsp_valid_ff;
   pix_type              rsp_pixel_ff;
   logic                 rsp_last_ff;

   // handshake
   logic                 accept;
   logic                 fire;

   // position logic
   logic [WW-1:0]        lw_ext;
   logic [WW-1:0]        eff_width;
   logic [FRAME_H_W-1:0] eff_height;
   logic                 col_last;
   logic                 row_last;

   // datapath
   err_type              ram_rd_data;
   err_type              above_raw;
   err_type              above;
   logic signed [10:0]   sum;
   pix_type              clamped;
   pix_type              v_sel;
   pix_type              q;
   err_type              e;
   err_type              t7, t5, t3, t1;

   logic                 mem_wr_en;
   logic [AW-1:0]        mem_wr_addr;
   err_type              mem_wr_data;

   assign fire      = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || fire;
   assign accept    = req_valid && req_ready;

   assign lw_ext     = WW'(line_width_ff);
   assign eff_width  = (lw_ext == '0) ? WW'(1) :
                       (lw_ext > WW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : lw_ext;
   assign eff_height = (frame_height_ff == '0) ? FRAME_H_W'(1) : frame_height_ff;
   assign col_last   = (WW'(col_ff) + WW'(1)) >= eff_width;
   assign row_last   = ({1'b0, row_ff} + 13'd1) >= {1'b0, eff_height};

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (col_last) begin
            col_in = '0;
            row_in = row_last ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   edd_ram #(
      .WIDTH (ERR_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_buf (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (ram_rd_data)
   );

   // newest value of this column's entry
   always_comb begin
      if (pend_valid_ff && (pend_addr_ff == s1_col_ff)) begin
         above_raw = pend_ff;
      end else if (byp_hit_ff) begin
         above_raw = byp_data_ff;
      end else begin
         above_raw = ram_rd_data;
      end
   end

   assign above = s1_row_zero_ff ? '0 : above_raw;
   assign sum   = $signed({3'b000, s1_pix_ff}) + 11'(right_carry_ff) + 11'(above);

   always_comb begin
      if (sum < 0) begin
         clamped = '0;
      end else if (sum > 11'sd255) begin
         clamped = 8'd255;
      end else begin
         clamped = sum[7:0];
      end
   end

   assign v_sel = diffuse_ff ? clamped : s1_pix_ff;
   assign q     = quantize(v_sel, two_level_ff);
   assign e     = diffuse_ff ? ($signed({1'b0, v_sel}) - $signed({1'b0, q})) : '0;
   assign t7    = weight_term(e, 3'd7);
   assign t5    = weight_term(e, 3'd5);
   assign t3    = weight_term(e, 3'd3);
   assign t1    = weight_term(e, 3'd1);

   always_comb begin
      mem_wr_en   = 1'b0;
      mem_wr_addr = pend_addr_ff;
      mem_wr_data = pend_ff;
      if (s1_col_ff != '0) begin
         // previous column gets its below-left term and is final
         mem_wr_en   = fire && !s1_last_row_ff;
         mem_wr_addr = s1_col_ff - 1'b1;
         mem_wr_data = pend_ff + t3;
      end else begin
         // flush the last column of the row before
         mem_wr_en = fire && pend_valid_ff;
      end
   end

   // in the last row the entry keeps its old value
   assign pend_in = s1_last_row_ff ? above_raw : below_right_ff + t5;

   assign right_carry_in = s1_last_col_ff ? '0 : t7;
   assign below_right_in = s1_last_col_ff ? '0 : t1;

   always_ff @(posedge clock) begin
      if (reset) begin
         two_level_ff    <= TWO_LEVEL_RST;
         diffuse_ff      <= DIFFUSE_RST;
         line_width_ff   <= LINE_WIDTH_RST;
         frame_height_ff <= FRAME_HEIGHT_RST;
         col_ff          <= '0;
         row_ff          <= '0;
         s1_valid_ff     <= 1'b0;
         pend_valid_ff   <= 1'b0;
         right_carry_ff  <= '0;
         below_right_ff  <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_TWO_LEVEL:    two_level_ff    <= csr_wdata[0];
               CSR_DIFFUSE:      diffuse_ff      <= csr_wdata[0];
               CSR_LINE_WIDTH:   line_width_ff   <= csr_wdata[LINE_W_W-1:0];
               CSR_FRAME_HEIGHT: frame_height_ff <= csr_wdata[FRAME_H_W-1:0];
               default: ;
            endcase
         end
         col_ff <= col_in;
         row_ff <= row_in;
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (fire) begin
            s1_valid_ff <= 1'b0;
         end
         if (fire) begin
            pend_valid_ff  <= 1'b1;
            right_carry_ff <= right_carry_in;
            below_right_ff <= below_right_in;
            rsp_valid_ff   <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff      <= req_pixel_in;
         s1_col_ff      <= col_ff;
         s1_row_zero_ff <= (row_ff == '0);
         s1_last_col_ff <= col_last;
         s1_last_row_ff <= row_last;
         byp_hit_ff     <= mem_wr_en && (mem_wr_addr == col_ff);
         byp_data_ff    <= mem_wr_data;
      end
      if (fire) begin
         pend_ff      <= pend_in;
         pend_addr_ff <= s1_col_ff;
         rsp_pixel_ff <= q;
         rsp_last_ff  <= s1_last_col_ff && s1_last_row_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pixel_out  = rsp_pixel_ff;
   assign rsp_frame_last = rsp_last_ff;

endmodule

[tb/error_diffusion_dither_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// error_diffusion_dither_tb
// Self-checking bench for the Floyd-Steinberg requantizer. A small directed run
// covers level boundaries, both modes, diffusion off and the width and height
// extremes. Randomized runs then follow with register changes between them.
// Every accepted pixel goes into a dither predictor that keeps its own line
// buffer. Each output transaction is compared in order against the prediction.
// ----------------------------------------------------------------------------
import edd_pkg::*;

typedef struct {
   pix_type pixel;
   logic    last;
} dither_out_type;

class dither_scoreboard;
   localparam int LINE_BUF_DEPTH = 1024;

   logic                  two_level;
   logic                  diffuse;
   logic [LINE_W_W-1:0]   width_reg;
   logic [FRAME_H_W-1:0]  height_reg;
   int                    col;
   int                    row;
   int                    carry_right;
   int                    carry_below_right;
   int                    corrections [LINE_BUF_DEPTH];
   dither_out_type        dithered_queue [$];
   int                    failures;

   function new();
      two_level         = TWO_LEVEL_RST;
      diffuse           = DIFFUSE_RST;
      width_reg         = LINE_WIDTH_RST;
      height_reg        = FRAME_HEIGHT_RST;
      col               = 0;
      row               = 0;
      carry_right       = 0;
      carry_below_right = 0;
      failures          = 0;
      foreach (corrections[i]) corrections[i] = 0;
   endfunction

   function int width_of(input int raw);
      if (raw == 0) return 1;
      if (raw > LINE_BUF_DEPTH) return LINE_BUF_DEPTH;
      return raw;
   endfunction

   function int height_of(input int raw);
      return (raw == 0) ? 1 : raw;
   endfunction

   function int pending();
      return dithered_queue.size();
   endfunction

   // growing the image is only allowed where no never-written line buffer
   // entry can be read afterwards
   function bit write_allowed(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_LINE_WIDTH: begin
            return width_of(data[LINE_W_W-1:0]) <= width_of(width_reg) || row == 0;
         end
         CSR_FRAME_HEIGHT: begin
            return height_of(data[FRAME_H_W-1:0]) <= height_of(height_reg) ||
                   (row == 0 && (col == 0 || height_of(height_reg) > 1));
         end
         default: return 1'b1;
      endcase
   endfunction

   function void set_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_TWO_LEVEL:    two_level  = data[0];
         CSR_DIFFUSE:      diffuse    = data[0];
         CSR_LINE_WIDTH:   width_reg  = data[LINE_W_W-1:0];
         CSR_FRAME_HEIGHT: height_reg = data[FRAME_H_W-1:0];
         default: ;
      endcase
   endfunction

   function void take_pixel(input pix_type pix);
      int             v;
      int             q;
      int             e;
      bit             last_col;
      bit             last_row;
      dither_out_type res;
      last_col = (col + 1) >= width_of(width_reg);
      last_row = (row + 1) >= height_of(height_reg);
      v = int'(pix);
      if (diffuse) begin
         v = v + carry_right + ((row != 0) ? corrections[col] : 0);
         if (v < 0) v = 0;
         if (v > 255) v = 255;
      end
      q = two_level ? (v / 128) * 255 : (v / 16) * 17;
      e = diffuse ? v - q : 0;
      if (!last_row) begin
         if (col > 0) corrections[col - 1] += e * 3 / 16;
         corrections[col] = carry_below_right + e * 5 / 16;
      end
      if (last_col) begin
         carry_right       = 0;
         carry_below_right = 0;
         col               = 0;
         row               = last_row ? 0 : row + 1;
      end else begin
         carry_right       = e * 7 / 16;
         carry_below_right = e * 1 / 16;
         col               = col + 1;
      end
      res.pixel = pix_type'(q);
      res.last  = last_col && last_row;
      dithered_queue.push_back(res);
   endfunction

   function void check_output(input pix_type pix, input logic last);
      dither_out_type exp_res;
      if (dithered_queue.size() == 0) begin
         $error("output transaction with none predicted: pixel_out %0d", pix);
         failures++;
         return;
      end
      exp_res = dithered_queue.pop_front();
      if (pix !== exp_res.pixel) begin
         $error("pixel_out: expected %0d, actual %0d", exp_res.pixel, pix);
         failures++;
      end
      if (last !== exp_res.last) begin
         $error("frame_last: expected %0b, actual %0b", exp_res.last, last);
         failures++;
      end
   endfunction
endclass

module error_diffusion_dither_tb;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_ITEMS = 450;
   localparam int HOLD_CYCLES  = 80;

   localparam pix_type DIRECTED_PIX [25] = '{
      8'd0,   8'd255, 8'd128, 8'd127, 8'd16,  8'd15,
      8'd255, 8'd0,   8'd200, 8'd100, 8'd50,  8'd8,  8'd247, 8'd1,
      8'd127, 8'd128, 8'd255, 8'd0,
      8'd255, 8'd170, 8'd15,
      8'd200, 8'd60,  8'd255, 8'd90
   };

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   pix_type               req_pixel_in;
   logic                  rsp_valid;
   logic                  rsp_ready;
   pix_type               rsp_pixel_out;
   logic                  rsp_frame_last;
   logic                  csr_wr_en;
   csr_index_type         csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   bit                    gaps_on;
   bit                    hold_request;
   int                    cycle_count;
   dither_scoreboard      sb = new();

   error_diffusion_dither dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_pixel_in   (req_pixel_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_pixel_out  (rsp_pixel_out),
      .rsp_frame_last (rsp_frame_last),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.take_pixel(req_pixel_in);
         if (rsp_valid && rsp_ready) sb.check_output(rsp_pixel_out, rsp_frame_last);
      end
   end

   // output side, with an occasional long hold-off
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            stall_left   = HOLD_CYCLES;
         end
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= !(gaps_on && $urandom_range(99) < 37);
         end
         @(posedge clock);
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("error_diffusion_dither_tb: errors");
      $finish;
   end

   task automatic offer_pixel(input pix_type pix);
      while (gaps_on && $urandom_range(99) < 37) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_pixel_in <= pix;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // leaves csr_wr_en high; the caller drops it after the last write
   task automatic program_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      if (sb.write_allowed(idx, data)) begin
         csr_wr_en <= 1'b1;
         csr_index <= idx;
         csr_wdata <= data;
         @(posedge clock);
         sb.set_reg(idx, data);
      end
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   function automatic logic [CSR_DATA_W-1:0] pick_setting(input csr_index_type idx);
      int                    roll;
      logic [CSR_DATA_W-1:0] val;
      roll = $urandom_range(99);
      case (idx)
         CSR_TWO_LEVEL: begin
            // upper bits of the write data are junk for one-bit registers
            if (roll < 25) val = $urandom;
            else val = $urandom_range(1);
         end
         CSR_DIFFUSE: begin
            if (roll < 15) val = $urandom;
            else val = (roll < 75) ? 1 : 0;
         end
         CSR_LINE_WIDTH: begin
            if (roll < 55)      val = $urandom_range(8, 1);
            else if (roll < 75) val = $urandom_range(40, 9);
            else if (roll < 83) val = 0;
            else if (roll < 90) val = 1024;
            else if (roll < 95) val = $urandom_range(2047, 1025);
            else                val = $urandom_range(1023, 41);
         end
         default: begin
            if (roll < 50)      val = $urandom_range(4, 1);
            else if (roll < 80) val = $urandom_range(12, 5);
            else if (roll < 88) val = 0;
            else if (roll < 94) val = 4095;
            else                val = $urandom_range(4094, 13);
         end
      endcase
      return val;
   endfunction

   initial begin
      int      random_left;
      int      phase_len;
      int      phase_no;
      int      roll;
      pix_type flat_level;
      pix_type pix;

      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_pixel_in <= '0;
      csr_wr_en    <= 1'b0;
      csr_index    <= CSR_TWO_LEVEL;
      csr_wdata    <= '0;
      gaps_on      = 1'b1;
      hold_request = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // reset settings: level edges at the start of a wide first row
      for (int i = 0; i < 6; i++) offer_pixel(DIRECTED_PIX[i]);
      drain_results();

      // narrow the line mid-row, short frame with diffusion into later rows
      program_reg(CSR_LINE_WIDTH, 4);
      program_reg(CSR_FRAME_HEIGHT, 3);
      program_reg(CSR_TWO_LEVEL, 0);
      program_reg(CSR_DIFFUSE, 1);
      csr_wr_en <= 1'b0;
      for (int i = 6; i < 14; i++) offer_pixel(DIRECTED_PIX[i]);
      drain_results();

      // black/white on a 1x1 image, cut in the middle of the last row
      program_reg(CSR_TWO_LEVEL, 1);
      program_reg(CSR_LINE_WIDTH, 1);
      program_reg(CSR_FRAME_HEIGHT, 1);
      csr_wr_en <= 1'b0;
      for (int i = 14; i < 18; i++) offer_pixel(DIRECTED_PIX[i]);
      drain_results();

      // plain requantization, zero width and height act as one
      program_reg(CSR_DIFFUSE, 0);
      program_reg(CSR_TWO_LEVEL, 0);
      program_reg(CSR_LINE_WIDTH, 0);
      program_reg(CSR_FRAME_HEIGHT, 0);
      csr_wr_en <= 1'b0;
      for (int i = 18; i < 21; i++) offer_pixel(DIRECTED_PIX[i]);
      drain_results();

      // oversized width clips to the line buffer depth, tallest frame
      program_reg(CSR_DIFFUSE, 1);
      program_reg(CSR_LINE_WIDTH, 2047);
      program_reg(CSR_FRAME_HEIGHT, 4095);
      csr_wr_en <= 1'b0;
      for (int i = 21; i < 25; i++) offer_pixel(DIRECTED_PIX[i]);
      drain_results();

      random_left = RANDOM_ITEMS;
      phase_no    = 0;
      while (random_left > 0) begin
         for (int r = 0; r < 4; r++) begin
            if ($urandom_range(99) < 40) begin
               program_reg(csr_index_type'(r), pick_setting(csr_index_type'(r)));
            end
         end
         csr_wr_en <= 1'b0;
         gaps_on = !(phase_no >= 2 && phase_no <= 4);
         // fill the block while the output side is held off
         if (phase_no == 3) hold_request = 1'b1;
         phase_len  = (phase_no == 3) ? 60 : $urandom_range(50, 10);
         flat_level = $urandom_range(255);
         if (phase_len > random_left) phase_len = random_left;
         repeat (phase_len) begin
            roll = $urandom_range(99);
            if (roll < 15)      pix = ($urandom_range(1) != 0) ? 8'd255 : 8'd0;
            else if (roll < 40) pix = flat_level;
            else                pix = $urandom_range(255);
            offer_pixel(pix);
         end
         drain_results();
         random_left -= phase_len;
         phase_no++;
      end

      repeat (8) @(posedge clock);
      if (sb.pending() != 0) begin
         $error("%0d predicted pixels never came out", sb.pending());
         sb.failures++;
      end
      if (sb.failures == 0) begin
         $display("error_diffusion_dither_tb: clean");
      end else begin
         $display("error_diffusion_dither_tb: errors");
      end
      $finish;
   end

endmodule

[sim.f]
hdl/edd_pkg.sv
hdl/edd_ram.sv
hdl/error_diffusion_dither.sv
tb/error_diffusion_dither_tb.sv
